[rtl/core/assert_macros.svh]
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked at every clock edge outside reset.
`define CHK_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication checked outside reset.
`define CHK_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`endif

[rtl/core/cts_pkg.sv]
// ----------------------------------------------------------------------------
// cts_pkg
// Token kinds, scanner modes, result types and a byte classifier for the token scanner.
// ----------------------------------------------------------------------------
package cts_pkg;

    localparam logic [3:0] K_IDENT   = 4'd0;
    localparam logic [3:0] K_INT     = 4'd1;
    localparam logic [3:0] K_FLOAT   = 4'd2;
    localparam logic [3:0] K_CHAR    = 4'd3;
    localparam logic [3:0] K_STRING  = 4'd4;
    localparam logic [3:0] K_OP      = 4'd5;
    localparam logic [3:0] K_DELIM   = 4'd6;
    localparam logic [3:0] K_DIR     = 4'd7;
    localparam logic [3:0] K_LINE    = 4'd8;
    localparam logic [3:0] K_BLOCK   = 4'd9;
    localparam logic [3:0] K_INVALID = 4'd10;

    localparam logic [3:0] M_NEW   = 4'd0;
    localparam logic [3:0] M_IDENT = 4'd1;
    localparam logic [3:0] M_NUM   = 4'd2;
    localparam logic [3:0] M_CHAR  = 4'd3;
    localparam logic [3:0] M_STR   = 4'd4;
    localparam logic [3:0] M_DIR   = 4'd5;
    localparam logic [3:0] M_LINE  = 4'd6;
    localparam logic [3:0] M_BLOCK = 4'd7;
    localparam logic [3:0] M_BAD   = 4'd8;
    localparam logic [3:0] M_PEND  = 4'd9;

    localparam logic RC_NUMERIC = 1'b0;
    localparam logic RC_PRINT   = 1'b1;

    localparam int MAX_RES = 3;

    // Relative start of an emitted token: from the token start register,
    // one past it, or the current byte.
    localparam logic [1:0] SRC_TOK  = 2'd0;
    localparam logic [1:0] SRC_TOK1 = 2'd1;
    localparam logic [1:0] SRC_POS  = 2'd2;

    // Length of an emitted token: the running count or a small constant.
    localparam logic [1:0] LEN_RUN = 2'd0;
    localparam logic [1:0] LEN_1   = 2'd1;
    localparam logic [1:0] LEN_2   = 2'd2;
    localparam logic [1:0] LEN_3   = 2'd3;

    typedef struct packed {
        logic       vld;
        logic [3:0] kind;
        logic [1:0] src;
        logic [1:0] len;
    } emit_t;

    typedef struct packed {
        logic       space;
        logic       digit;
        logic       alpha;
        logic       print;
        logic       punct;
        logic       delim;
        logic       op_lead;
    } cls_t;

    function automatic cls_t classify(input logic [7:0] c);
        cls_t r;
        r.space   = (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
        r.digit   = (c >= "0" && c <= "9");
        r.alpha   = (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
        r.print   = (c >= 8'h20 && c <= 8'h7E);
        r.punct   = (c >= 8'h21 && c <= 8'h7E) && !(r.digit || r.alpha);
        r.delim   = (c == "(") || (c == ")") || (c == ":") || (c == ";") || (c == "[")
                 || (c == "]") || (c == "{") || (c == "}") || (c == ",");
        r.op_lead = (c == "!") || (c == "%") || (c == "*") || (c == "=") || (c == "^")
                 || (c == "&") || (c == "|") || (c == "+") || (c == "-") || (c == "/")
                 || (c == "<") || (c == ">") || (c == ".");
        return r;
    endfunction

endpackage

[rtl/core/cts_fsm.sv]
// ----------------------------------------------------------------------------
// cts_fsm
// Next-state and token-emit logic for one byte or end marker.
// ----------------------------------------------------------------------------
module cts_fsm (
    input  logic [3:0]          mode,
    input  logic                seen_dot,
    input  logic                prev_star,
    input  logic                prev_bs,
    input  logic                rcls,
    input  logic [7:0]          pend0,
    input  logic                pend2,
    input  logic [7:0]          c,
    input  logic                is_end,
    output logic [3:0]          mode_n,
    output logic                seen_dot_n,
    output logic                prev_star_n,
    output logic                prev_bs_n,
    output logic                rcls_n,
    output logic [7:0]          pend0_n,
    output logic                pend2_n,
    output logic                len_inc,
    output logic [1:0]          len_set,
    output logic                len_load,
    output logic                tok_at_pos,
    output cts_pkg::emit_t [2:0] em
);
    import cts_pkg::*;

    cls_t       k;
    logic       restart;
    logic       two;
    logic [1:0] n;

    always_comb begin
        k = classify(c);
        mode_n = mode;
        seen_dot_n = seen_dot;
        prev_star_n = prev_star;
        prev_bs_n = prev_bs;
        rcls_n = rcls;
        pend0_n = pend0;
        pend2_n = pend2;
        len_inc = 1'b0;
        len_set = 2'd0;
        len_load = 1'b0;
        tok_at_pos = 1'b0;
        restart = 1'b0;
        two = 1'b0;
        n = 2'd0;
        em = '0;

        if (is_end) begin
            unique case (mode)
                M_IDENT: begin em[0] = '{1'b1, K_IDENT, SRC_TOK, LEN_RUN}; end
                M_NUM: begin
                    em[0] = '{1'b1, seen_dot ? K_FLOAT : K_INT, SRC_TOK, LEN_RUN};
                end
                M_DIR: begin
                    em[0] = '{1'b1, K_INVALID, SRC_TOK, LEN_RUN};
                    len_inc = prev_bs;
                end
                M_CHAR, M_STR, M_LINE, M_BLOCK, M_BAD: begin
                    em[0] = '{1'b1, K_INVALID, SRC_TOK, LEN_RUN};
                end
                M_PEND: begin
                    if (pend2 && pend0 == ".") begin
                        em[0] = '{1'b1, K_OP, SRC_TOK, LEN_1};
                        em[1] = '{1'b1, K_OP, SRC_TOK1, LEN_1};
                    end else if (pend2) begin
                        em[0] = '{1'b1, K_OP, SRC_TOK, LEN_2};
                    end else begin
                        em[0] = '{1'b1, K_OP, SRC_TOK, LEN_1};
                    end
                end
                default: begin end
            endcase
            mode_n = M_NEW;
            seen_dot_n = 1'b0;
            prev_star_n = 1'b0;
            prev_bs_n = 1'b0;
            rcls_n = 1'b0;
            pend0_n = '0;
            pend2_n = 1'b0;
        end else begin
            unique case (mode)
                M_IDENT: begin
                    if (k.alpha || k.digit || c == "_") len_inc = 1'b1;
                    else begin
                        em[0] = '{1'b1, K_IDENT, SRC_TOK, LEN_RUN}; n = 2'd1; restart = 1'b1;
                    end
                end
                M_NUM: begin
                    if (c == ".") begin
                        if (seen_dot) begin mode_n = M_BAD; rcls_n = RC_NUMERIC; end
                        seen_dot_n = 1'b1;
                        len_inc = 1'b1;
                    end else if (k.digit) begin
                        len_inc = 1'b1;
                    end else if (k.alpha) begin
                        mode_n = M_BAD; rcls_n = RC_NUMERIC; len_inc = 1'b1;
                    end else begin
                        em[0] = '{1'b1, seen_dot ? K_FLOAT : K_INT, SRC_TOK, LEN_RUN};
                        n = 2'd1; restart = 1'b1;
                    end
                end
                M_CHAR, M_STR: begin
                    if ((mode == M_CHAR && c == "'") || (mode == M_STR && c == "\"")) begin
                        len_inc = 1'b1;
                        em[0] = '{1'b1, (mode == M_CHAR) ? K_CHAR : K_STRING, SRC_TOK,
                                  LEN_RUN};
                        mode_n = M_NEW;
                    end else if (c == 8'h0A) begin
                        em[0] = '{1'b1, K_INVALID, SRC_TOK, LEN_RUN}; n = 2'd1; restart = 1'b1;
                    end else len_inc = 1'b1;
                end
                M_DIR: begin
                    if (prev_bs && c == 8'h0A) begin
                        prev_bs_n = 1'b0;
                    end else if (c == "\\") begin
                        // A held backslash counts once the next byte is not a newline.
                        prev_bs_n = 1'b1;
                        len_inc = prev_bs;
                    end else if (c == 8'h0A) begin
                        em[0] = '{1'b1, K_DIR, SRC_TOK, LEN_RUN}; n = 2'd1; restart = 1'b1;
                    end else begin
                        prev_bs_n = 1'b0;
                        // Two increments when a backslash was held; handled as +2.
                        len_inc = 1'b1;
                        len_set = prev_bs ? 2'd2 : 2'd1;
                    end
                end
                M_LINE: begin
                    if (c == 8'h0A) begin
                        em[0] = '{1'b1, K_LINE, SRC_TOK, LEN_RUN}; n = 2'd1; restart = 1'b1;
                    end else len_inc = 1'b1;
                end
                M_BLOCK: begin
                    len_inc = 1'b1;
                    if (prev_star && c == "/") begin
                        em[0] = '{1'b1, K_BLOCK, SRC_TOK, LEN_RUN}; // length includes this byte
                        prev_star_n = 1'b0;
                        mode_n = M_NEW;
                    end else prev_star_n = (c == "*");
                end
                M_BAD: begin
                    if ((rcls == RC_NUMERIC) ? !(k.alpha || k.digit || c == ".") : k.print)
                    begin
                        em[0] = '{1'b1, K_INVALID, SRC_TOK, LEN_RUN}; n = 2'd1; restart = 1'b1;
                    end else len_inc = 1'b1;
                end
                M_PEND: begin
                    if (pend2) begin
                        pend2_n = 1'b0;
                        mode_n = M_NEW;
                        if (pend0 == ".") begin
                            if (c == ".") em[0] = '{1'b1, K_OP, SRC_TOK, LEN_3};
                            else begin
                                em[0] = '{1'b1, K_OP, SRC_TOK, LEN_1};
                                em[1] = '{1'b1, K_OP, SRC_TOK1, LEN_1};
                                n = 2'd2; restart = 1'b1;
                            end
                        end else begin
                            if (c == "=") em[0] = '{1'b1, K_OP, SRC_TOK, LEN_3};
                            else begin
                                em[0] = '{1'b1, K_OP, SRC_TOK, LEN_2}; n = 2'd1;
                                restart = 1'b1;
                            end
                        end
                    end else if (pend0 == "/" && c == "/") begin
                        mode_n = M_LINE; len_load = 1'b1; len_set = 2'd2;
                    end else if (pend0 == "/" && c == "*") begin
                        mode_n = M_BLOCK; len_load = 1'b1; len_set = 2'd2;
                        prev_star_n = 1'b0;
                    end else if ((pend0 == "<" || pend0 == ">" || pend0 == ".")
                                 && c == pend0) begin
                        pend2_n = 1'b1;
                    end else begin
                        priority case (pend0)
                            "&", "|", "+": two = (c == "=") || (c == pend0);
                            "-":           two = (c == "=") || (c == "-") || (c == ">");
                            ".":           two = 1'b0;
                            default:       two = (c == "=");
                        endcase
                        mode_n = M_NEW;
                        if (two) em[0] = '{1'b1, K_OP, SRC_TOK, LEN_2};
                        else begin
                            em[0] = '{1'b1, K_OP, SRC_TOK, LEN_1}; n = 2'd1; restart = 1'b1;
                        end
                    end
                end
                default: restart = 1'b1;
            endcase

            if (restart) begin
                mode_n = M_NEW;
                if (k.space) begin
                end else if (k.alpha || c == "_") begin
                    mode_n = M_IDENT; tok_at_pos = 1'b1;
                end else if (k.digit) begin
                    mode_n = M_NUM; tok_at_pos = 1'b1; seen_dot_n = 1'b0;
                end else if (c == "'") begin
                    mode_n = M_CHAR; tok_at_pos = 1'b1;
                end else if (c == "\"") begin
                    mode_n = M_STR; tok_at_pos = 1'b1;
                end else if (c == "#") begin
                    mode_n = M_DIR; tok_at_pos = 1'b1; prev_bs_n = 1'b0;
                end else if (k.delim) begin
                    em[n] = '{1'b1, K_DELIM, SRC_POS, LEN_1};
                end else if (k.op_lead) begin
                    mode_n = M_PEND; tok_at_pos = 1'b1; pend0_n = c; pend2_n = 1'b0;
                end else if (k.punct) begin
                    em[n] = '{1'b1, K_INVALID, SRC_POS, LEN_1};
                end else begin
                    mode_n = M_BAD; tok_at_pos = 1'b1; rcls_n = RC_PRINT;
                end
            end
        end
    end

endmodule

[rtl/core/c_like_token_scanner_core.sv]
// ----------------------------------------------------------------------------
// c_like_token_scanner_core
// Streaming C-like tokenizer: one source byte per word, up to three tokens out.
// ----------------------------------------------------------------------------
// The scanner takes one byte (or an end marker) per cycle while s_ready is
// high: the mode logic is a single combinational pass between the byte and the
// state registers. Each input word produces zero to three tokens, which are
// parked in a small result queue and drained one per cycle on the m_ side while
// m_ready is high; a token shows up on the m_ side in the cycle after the word
// that finishes it is accepted, if the queue held nothing older. The queue
// holds up to eight tokens; the s_ side is stalled only while fewer than three
// slots are free, so input runs at one byte per cycle as long as the consumer
// takes one token per cycle and the text does not yield more tokens than bytes.
// Lengths saturate at 2^LENGTH_BITS-1 and offsets wrap at 2^OFFSET_BITS; an end
// marker flushes the open token and restarts offsets at zero.
// ----------------------------------------------------------------------------
module c_like_token_scanner_core #(
    parameter int LENGTH_BITS = 16,
    parameter int OFFSET_BITS = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_char_code,
    input  logic        s_is_end,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [3:0]  m_token_kind,
    output logic [31:0] m_token_start,
    output logic [15:0] m_token_length,
    output logic        m_last_of_run
);
    import cts_pkg::*;

    localparam int QD = 8;
    localparam logic [LENGTH_BITS-1:0] LMAX = '1;

    typedef struct packed {
        logic [3:0]  kind;
        logic [31:0] start;
        logic [15:0] len;
        logic        last;
    } tok_t;

    // Scanner state.
    logic [3:0]             mode_reg;
    logic                   seen_dot_reg, prev_star_reg, prev_bs_reg, rcls_reg, pend2_reg;
    logic [7:0]             pend0_reg;
    logic [LENGTH_BITS-1:0] len_reg;
    logic [OFFSET_BITS-1:0] start_reg, pos_reg;

    logic [3:0]  mode_n;
    logic        seen_dot_n, prev_star_n, prev_bs_n, rcls_n, pend2_n, pend2_next;
    logic [7:0]  pend0_n;
    logic        len_inc, len_load, tok_at_pos;
    logic [1:0]  len_set;
    emit_t [2:0] em;

    cts_fsm u_fsm (
        .mode(mode_reg), .seen_dot(seen_dot_reg), .prev_star(prev_star_reg),
        .prev_bs(prev_bs_reg), .rcls(rcls_reg), .pend0(pend0_reg), .pend2(pend2_reg),
        .c(s_char_code), .is_end(s_is_end),
        .mode_n(mode_n), .seen_dot_n(seen_dot_n), .prev_star_n(prev_star_n),
        .prev_bs_n(prev_bs_n), .rcls_n(rcls_n), .pend0_n(pend0_n), .pend2_n(pend2_n),
        .len_inc(len_inc), .len_set(len_set), .len_load(len_load),
        .tok_at_pos(tok_at_pos), .em(em)
    );
    assign pend2_next = pend2_n;

    // Length including the increment for this byte; used both for the token
    // emitted now (closing quote, block end, end-marker backslash) and next.
    logic [LENGTH_BITS-1:0] len_now;
    always_comb begin
        len_now = len_reg;
        if (len_inc) begin
            if (len_set == 2'd2 && len_reg < LMAX - LENGTH_BITS'(1)) len_now = len_reg + 2'd2;
            else if (len_reg != LMAX) begin
                len_now = (len_set == 2'd2) ? LMAX : len_reg + 1'b1;
            end
        end
    end

    logic [LENGTH_BITS-1:0] len_sat16;
    assign len_sat16 = len_now;

    function automatic logic [15:0] lenf(input logic [1:0] l, input logic [LENGTH_BITS-1:0] r);
        unique case (l)
            LEN_RUN: lenf = 16'(r);
            LEN_1:   lenf = 16'd1;
            LEN_2:   lenf = 16'd2;
            default: lenf = 16'd3;
        endcase
    endfunction

    tok_t [2:0] tk;
    logic [1:0] cnt;
    always_comb begin
        cnt = 2'(32'(em[0].vld) + 32'(em[1].vld) + 32'(em[2].vld));
        for (int i = 0; i < MAX_RES; i++) begin
            tk[i].kind = em[i].kind;
            unique case (em[i].src)
                SRC_TOK:  tk[i].start = 32'(start_reg);
                SRC_TOK1: tk[i].start = 32'(start_reg + OFFSET_BITS'(1));
                default:  tk[i].start = 32'(pos_reg);
            endcase
            tk[i].len = lenf(em[i].len, len_sat16);
            tk[i].last = em[i].vld && (i == MAX_RES - 1 || !em[(i + 1) % MAX_RES].vld
                                       || i == 2);
        end
        if (em[1].vld) tk[0].last = 1'b0;
    end

    // Result queue.
    tok_t       q_mem [QD];
    logic [2:0] wp_reg, rp_reg;
    logic [3:0] qn_reg;
    logic       acc, pop;

    assign s_ready = (qn_reg <= 4'(QD - MAX_RES));
    assign acc     = s_valid && s_ready;
    assign m_valid = (qn_reg != 4'd0);
    assign pop     = m_valid && m_ready;
    assign m_token_kind   = q_mem[rp_reg].kind;
    assign m_token_start  = q_mem[rp_reg].start;
    assign m_token_length = q_mem[rp_reg].len;
    assign m_last_of_run  = q_mem[rp_reg].last;

    always_ff @(posedge aclk) begin
        if (acc) begin
            for (int i = 0; i < MAX_RES; i++) begin
                if (32'(i) < 32'(cnt)) q_mem[3'(wp_reg + 3'(i))] <= tk[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg <= '0;
            rp_reg <= '0;
            qn_reg <= '0;
            mode_reg <= M_NEW;
            seen_dot_reg <= 1'b0;
            prev_star_reg <= 1'b0;
            prev_bs_reg <= 1'b0;
            rcls_reg <= 1'b0;
            pend0_reg <= '0;
            pend2_reg <= 1'b0;
            len_reg <= '0;
            start_reg <= '0;
            pos_reg <= '0;
        end else begin
            if (acc) wp_reg <= wp_reg + 3'(cnt);
            if (pop) rp_reg <= rp_reg + 3'd1;
            qn_reg <= qn_reg + (acc ? 4'(cnt) : 4'd0) - (pop ? 4'd1 : 4'd0);
            if (acc) begin
                mode_reg <= mode_n;
                seen_dot_reg <= seen_dot_n;
                prev_star_reg <= prev_star_n;
                prev_bs_reg <= prev_bs_n;
                rcls_reg <= rcls_n;
                pend0_reg <= pend0_n;
                pend2_reg <= pend2_next;
                if (s_is_end) begin
                    len_reg <= '0;
                    start_reg <= '0;
                    pos_reg <= '0;
                end else begin
                    pos_reg <= pos_reg + OFFSET_BITS'(1);
                    if (tok_at_pos) begin
                        start_reg <= pos_reg;
                        len_reg <= LENGTH_BITS'(1);
                    end else if (len_load) begin
                        len_reg <= LENGTH_BITS'(len_set);
                    end else begin
                        len_reg <= len_now;
                    end
                end
            end
        end
    end

endmodule

[rtl/core/cts_checker.sv]
// ----------------------------------------------------------------------------
// cts_checker
// Port-level checks on the token scanner's channels.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module cts_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [3:0]  m_token_kind,
    input logic [15:0] m_token_length,
    input logic [31:0] m_token_start
);
    `CHK_IMPL(a_kind_range, aclk, aresetn, m_valid, m_token_kind <= 4'd10, "bad token kind")
    `CHK_IMPL(a_len_nonzero, aclk, aresetn, m_valid, m_token_length != 16'd0, "zero length")
    `CHK_NEXT(a_m_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_token_start), "result dropped")
    `CHK_NEXT(a_idle_ready, aclk, aresetn, !m_valid && !s_valid, s_ready, "stalled while empty")
endmodule

bind c_like_token_scanner_core cts_checker u_cts_checker (
    .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
    .m_valid(m_valid), .m_ready(m_ready), .m_token_kind(m_token_kind),
    .m_token_length(m_token_length), .m_token_start(m_token_start)
);
